// File: rtl/core/rspa_pkg.sv
// Types, constants and helpers for the reserved-slot pool allocator.
// Depends on nothing; imported by reserved_slot_pool_allocator_unit.
`timescale 1ns / 1ps

package rspa_pkg;

    localparam int POOL_SLOTS = 16;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 5;
    localparam int KIND_W     = 3;

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [KIND_W-1:0]
    {
        KIND_GENERAL       = 3'd0,
        KIND_UPDATE        = 3'd1,
        KIND_FETCH         = 3'd2,
        KIND_POST_REPLAY   = 3'd3,
        KIND_POST_ACK      = 3'd4,
        KIND_POST_PERIODIC = 3'd5
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FAIL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Reserved slots at the top of the pool.
    localparam logic [SLOT_W-1:0] SLOT_UPDATE        = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_FETCH         = SLOT_W'(POOL_SLOTS - 2);
    localparam logic [SLOT_W-1:0] SLOT_POST_REPLAY   = SLOT_W'(POOL_SLOTS - 3);
    localparam logic [SLOT_W-1:0] SLOT_POST_ACK      = SLOT_W'(POOL_SLOTS - 4);
    localparam logic [SLOT_W-1:0] SLOT_POST_PERIODIC = SLOT_W'(POOL_SLOTS - 5);

    // Shared slots 0..N-6; update may fall back to anything below its own slot.
    localparam logic [POOL_SLOTS-1:0] SHARED_MASK =
        POOL_SLOTS'((64'd1 << (POOL_SLOTS - 5)) - 64'd1);
    localparam logic [POOL_SLOTS-1:0] UPDATE_MASK = {1'b0, {(POOL_SLOTS - 1){1'b1}}};

    typedef struct packed
    {
        logic              func;
        logic [KIND_W-1:0] request_kind;
        logic [INDEX_W-1:0] free_index;
    } req_t;

    typedef struct packed
    {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] busy_count;
    } rsp_t;

    typedef struct packed
    {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } pick_t;

    // Lowest set bit of avail.
    function automatic pick_t first_free(input logic [POOL_SLOTS-1:0] avail);
        pick_t p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                p.found = 1'b1;
                p.idx   = SLOT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/core/reserved_slot_pool_allocator_unit.sv
// Reserved-slot pool allocator: top level, one register stage per side.
// Depends on rspa_pkg (types, slot constants, first_free).
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | func, request_kind, free_index
//  rsp     | out       | rsp_valid / rsp_ready | status, slot_index, busy_count
//
//  One request per cycle sustained while rsp is not stalled; a transfer on req goes
//  to the request register, then to the response register. The rate is set by the
//  read-modify-write of the busy vector and busy counter, which sits between the two.
//  Reset clears the busy flags, the counter and both valid flags; no clearing pass.
//  A stalled rsp holds its register; req is still taken while the request register
//  is empty or drains into the response register in the same cycle.

module reserved_slot_pool_allocator_unit
    import rspa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Request register.
    logic req_vld_reg;
    req_t req_reg;

    // Pool state.
    logic [POOL_SLOTS-1:0] slot_busy_reg;
    logic [POOL_SLOTS-1:0] slot_busy_next;
    logic [COUNT_W-1:0]    busy_count_reg;
    logic [COUNT_W-1:0]    busy_count_next;

    // Response register.
    logic rsp_vld_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // Working signals for the step.
    logic                  advance;
    logic                  own_en;
    logic [SLOT_W-1:0]     own_idx;
    logic [POOL_SLOTS-1:0] fall_mask;
    pick_t                 fall_pick;
    logic                  grant_ok;
    logic [SLOT_W-1:0]     grant_idx;
    logic                  free_in_range;
    logic [SLOT_W-1:0]     free_slot;

    // The request register moves on whenever the response register is free or drains.
    assign advance   = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || advance;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    assign free_in_range = (req_reg.free_index < INDEX_W'(POOL_SLOTS));
    assign free_slot     = req_reg.free_index[SLOT_W-1:0];

    // Own slot and fallback range by kind; unused kinds act as general.
    always_comb
    begin
        own_en    = 1'b1;
        own_idx   = SLOT_FETCH;
        fall_mask = SHARED_MASK;
        unique case (req_reg.request_kind)
            KIND_UPDATE:
            begin
                own_idx   = SLOT_UPDATE;
                fall_mask = UPDATE_MASK;
            end
            KIND_FETCH:         own_idx = SLOT_FETCH;
            KIND_POST_REPLAY:   own_idx = SLOT_POST_REPLAY;
            KIND_POST_ACK:      own_idx = SLOT_POST_ACK;
            KIND_POST_PERIODIC: own_idx = SLOT_POST_PERIODIC;
            default:            own_en  = 1'b0;
        endcase
    end

    assign fall_pick = first_free(~slot_busy_reg & fall_mask);

    // Own slot wins over the fallback search.
    always_comb
    begin
        if (own_en && !slot_busy_reg[own_idx])
        begin
            grant_ok  = 1'b1;
            grant_idx = own_idx;
        end
        else
        begin
            grant_ok  = fall_pick.found;
            grant_idx = fall_pick.idx;
        end
    end

    // State update and response; the counter tracks the busy flags incrementally.
    always_comb
    begin
        slot_busy_next      = slot_busy_reg;
        busy_count_next     = busy_count_reg;
        rsp_next.status     = ST_DONE;
        rsp_next.slot_index = '0;
        if (req_reg.func == FUNC_FREE)
        begin
            if (free_in_range)
            begin
                rsp_next.slot_index = free_slot;
                if (slot_busy_reg[free_slot])
                begin
                    slot_busy_next[free_slot] = 1'b0;
                    busy_count_next           = busy_count_reg - COUNT_W'(1);
                end
            end
            else
            begin
                rsp_next.status = ST_RANGE;
            end
        end
        else
        begin
            if (grant_ok)
            begin
                rsp_next.slot_index       = grant_idx;
                slot_busy_next[grant_idx] = 1'b1;
                busy_count_next           = busy_count_reg + COUNT_W'(1);
            end
            else
            begin
                rsp_next.status = ST_FAIL;
            end
        end
        rsp_next.busy_count = busy_count_next;
    end

    // Control and pool state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg    <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            slot_busy_reg  <= '0;
            busy_count_reg <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_vld_reg    <= 1'b1;
                slot_busy_reg  <= slot_busy_next;
                busy_count_reg <= busy_count_next;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Counter always agrees with the flags it summarizes.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        busy_count_reg == COUNT_W'($countones(slot_busy_reg)))
        else $error("busy counter out of step with busy flags");

    // A granted slot is busy right after the step.
    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req_reg.func == FUNC_ALLOC && grant_ok
        |=> slot_busy_reg[$past(grant_idx)])
        else $error("granted slot not marked busy");

    // Failed or rejected steps report slot zero.
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && rsp_reg.status != ST_DONE |-> rsp_reg.slot_index == '0)
        else $error("nonzero slot index on failed step");

    // Back-pressure on req only while the request register holds a stuck item.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> req_vld_reg && rsp_vld_reg && !rsp_ready)
        else $error("request side stalled without cause");

endmodule
